@@ rtl/core/pcmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmc_pkg
// Shared codes and types for the PCM sample format converter.
// ----------------------------------------------------------------------------
package pcmc_pkg;

  localparam logic [2:0] FMT_U8   = 3'd0;
  localparam logic [2:0] FMT_S16  = 3'd1;
  localparam logic [2:0] FMT_S24L = 3'd2;
  localparam logic [2:0] FMT_S24R = 3'd3;
  localparam logic [2:0] FMT_S32  = 3'd4;
  localparam logic [2:0] FMT_FLT  = 3'd5;

  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_FORMAT    = 1'b1;

  localparam logic [31:0] FLT_POS_ONE = 32'h3F80_0000;
  localparam logic [31:0] FLT_NEG_ONE = 32'hBF80_0000;

  // per-stage advance strobes
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_en_t;

endpackage

@@ rtl/core/pcmc_i2f.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmc_i2f
// Integer sample to IEEE single, three register stages.
// ----------------------------------------------------------------------------
module pcmc_i2f (
  input  logic             clk,
  input  pcmc_pkg::pipe_en_t en,
  input  logic [2:0]       fmt,
  input  logic [31:0]      sample_i,
  output logic [31:0]      result_o
);
  import pcmc_pkg::*;

  // stage 1: sign/magnitude
  logic        sign_r, sign_nxt, pass_r, pass_nxt, zero_r, zero_nxt;
  logic [31:0] mag_r, mag_nxt, raw_r;
  logic [4:0]  sc_r, sc_nxt;
  logic signed [32:0] v;

  always_comb begin
    v        = '0;
    sc_nxt   = 5'd0;
    pass_nxt = 1'b0;
    zero_nxt = 1'b0;
    unique case (fmt)
      FMT_U8: begin
        v = $signed({25'd0, sample_i[7:0]}) - 33'sd128;
        sc_nxt = 5'd7;
      end
      FMT_S16: begin
        v = 33'(signed'(sample_i[15:0]));
        sc_nxt = 5'd15;
      end
      FMT_S24L: begin
        v = 33'(signed'(sample_i[31:8]));
        sc_nxt = 5'd23;
      end
      FMT_S24R: begin
        v = 33'(signed'(sample_i));
        sc_nxt = 5'd23;
      end
      FMT_S32: begin
        v = 33'(signed'(sample_i));
        sc_nxt = 5'd31;
      end
      FMT_FLT: pass_nxt = 1'b1;
      default: zero_nxt = 1'b1;
    endcase
    sign_nxt = v[32];
    mag_nxt  = sign_nxt ? 32'(-v) : v[31:0];
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      sign_r <= sign_nxt;
      mag_r  <= mag_nxt;
      sc_r   <= sc_nxt;
      pass_r <= pass_nxt;
      zero_r <= zero_nxt;
      raw_r  <= sample_i;
    end
  end

  // stage 2: leading-zero count and normalize
  logic [4:0]  lz_nxt, lz_r;
  logic [31:0] norm_r;
  logic        sign2_r, pass2_r, zero2_r;
  logic [4:0]  sc2_r;
  logic [31:0] raw2_r;

  always_comb begin
    lz_nxt = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag_r[i]) lz_nxt = 5'(31 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      lz_r    <= lz_nxt;
      norm_r  <= mag_r << lz_nxt;
      sign2_r <= sign_r;
      pass2_r <= pass_r;
      zero2_r <= zero_r | (mag_r == 32'd0);
      sc2_r   <= sc_r;
      raw2_r  <= raw_r;
    end
  end

  // stage 3: round to nearest even and pack
  logic [23:0] mant_rnd;
  logic        rnd_up;
  logic [7:0]  expo;
  logic [31:0] res_nxt;

  always_comb begin
    rnd_up   = norm_r[7] & ((|norm_r[6:0]) | norm_r[8]);
    mant_rnd = {1'b0, norm_r[30:8]} + 24'(rnd_up);
    expo     = 8'd158 - 8'(lz_r) - 8'(sc2_r) + 8'(mant_rnd[23]);
    priority if (pass2_r) res_nxt = raw2_r;
    else if (zero2_r)     res_nxt = 32'd0;
    else                  res_nxt = {sign2_r, expo, mant_rnd[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en.en3) result_o <= res_nxt;
  end

endmodule

@@ rtl/core/pcmc_f2i.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmc_f2i
// IEEE single to integer sample (or clipped float), three register stages.
// ----------------------------------------------------------------------------
module pcmc_f2i (
  input  logic             clk,
  input  pcmc_pkg::pipe_en_t en,
  input  logic [2:0]       fmt,
  input  logic [31:0]      sample_i,
  output logic [31:0]      result_o
);
  import pcmc_pkg::*;

  // stage 1: unpack, scale exponent
  logic [7:0]  ex;
  logic [22:0] fr;
  logic        nan;
  logic [4:0]  k;
  logic signed [9:0] t_nxt, t_r;
  logic        sign_r, big_r, ge1_r, flt_r;
  logic [23:0] mant_r;
  logic [2:0]  fmt_r;
  logic [31:0] flt_nxt, fltv_r;

  always_comb begin
    ex  = sample_i[30:23];
    fr  = sample_i[22:0];
    nan = (ex == 8'hFF) && (fr != 23'd0);
    unique case (fmt)
      FMT_U8:   k = 5'd7;
      FMT_S16:  k = 5'd15;
      FMT_S32:  k = 5'd31;
      default:  k = 5'd23;
    endcase
    t_nxt = $signed({2'b00, (ex == 8'd0) ? 8'd1 : ex}) + $signed({5'd0, k}) - 10'sd150;
    priority if (nan)                        flt_nxt = 32'd0;
    else if (sample_i[30:0] > FLT_POS_ONE[30:0])
      flt_nxt = sample_i[31] ? FLT_NEG_ONE : FLT_POS_ONE;
    else                                     flt_nxt = sample_i;
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      sign_r <= sample_i[31] & ~nan;
      mant_r <= nan ? 24'd0 : {ex != 8'd0, fr};
      t_r    <= t_nxt;
      big_r  <= ~nan & (t_nxt >= 10'sd10);
      ge1_r  <= ~nan & (ex >= 8'd127);
      fmt_r  <= fmt;
      fltv_r <= flt_nxt;
      flt_r  <= (fmt == FMT_FLT);
    end
  end

  // stage 2: align to integer with guard and sticky
  logic [33:0] q_nxt, q_r;
  logic        g_nxt, s_nxt, g_r, s_r;
  logic [9:0]  sh;
  logic [49:0] wide;
  logic        sign2_r, big2_r, ge12_r, flt2_r;
  logic [2:0]  fmt2_r;
  logic [31:0] fltv2_r;

  always_comb begin
    sh    = 10'(-t_r);
    wide  = {mant_r, 26'd0} >> sh[4:0];
    q_nxt = '0;
    g_nxt = 1'b0;
    s_nxt = 1'b0;
    if (!t_r[9]) begin
      q_nxt = 34'(mant_r) << t_r[3:0];
    end else if (sh >= 10'd26) begin
      s_nxt = |mant_r;
    end else begin
      q_nxt = 34'(wide[49:26]);
      g_nxt = wide[25];
      s_nxt = |wide[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      q_r     <= q_nxt;
      g_r     <= g_nxt;
      s_r     <= s_nxt;
      sign2_r <= sign_r;
      big2_r  <= big_r;
      ge12_r  <= ge1_r;
      fmt2_r  <= fmt_r;
      fltv2_r <= fltv_r;
      flt2_r  <= flt_r;
    end
  end

  // stage 3: round, apply sign, saturate, place
  localparam logic signed [35:0] BIG = 36'sh4_0000_0000;
  logic [34:0] r;
  logic signed [35:0] val, u, c;
  logic [31:0] res_nxt;

  always_comb begin
    r   = 35'(q_r) + 35'(g_r & (s_r | q_r[0]));
    val = sign2_r ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (big2_r) val = sign2_r ? -BIG : BIG;
    u   = val + 36'sd128;
    res_nxt = 32'd0;
    unique case (fmt2_r)
      FMT_U8: begin
        c = (u < 0) ? 36'sd0 : ((u > 36'sd255) ? 36'sd255 : u);
        res_nxt = {24'd0, c[7:0]};
      end
      FMT_S16: begin
        c = (val < -36'sd32768) ? -36'sd32768 : ((val > 36'sd32767) ? 36'sd32767 : val);
        res_nxt = {16'd0, c[15:0]};
      end
      FMT_S24L, FMT_S24R: begin
        priority if (ge12_r && !sign2_r) c = 36'sd8388480;
        else if (ge12_r)                 c = -36'sd8388608;
        else if (val > 36'sd8388607)     c = 36'sd8388607;
        else if (val < -36'sd8388608)    c = -36'sd8388608;
        else                             c = val;
        res_nxt = (fmt2_r == FMT_S24L) ? {c[23:0], 8'd0} : c[31:0];
      end
      FMT_S32: begin
        priority if (ge12_r && !sign2_r) c = 36'sd2147483520;
        else if (ge12_r)                 c = -36'sd2147483648;
        else if (val > 36'sd2147483647)  c = 36'sd2147483647;
        else if (val < -36'sd2147483648) c = -36'sd2147483648;
        else                             c = val;
        res_nxt = c[31:0];
      end
      default: c = '0;
    endcase
    if (flt2_r) res_nxt = fltv2_r;
  end

  always_ff @(posedge clk) begin
    if (en.en3) result_o <= res_nxt;
  end

endmodule

@@ rtl/core/pcm_sample_format_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_sample_format_converter
// PCM sample converter between integer formats and IEEE single precision.
//
// Usage:
// - in_* is a stream of sample items: in_tdata[31:0] the raw word, in_tlast
//   marks the last sample of a buffer. out_* carries the converted word and
//   the copied tlast.
// - cfg_* writes a register: index 0 direction (0 int->float, 1 float->int),
//   index 1 sample format (0 U8, 1 S16, 2 S24 left, 3 S24 low, 4 S32,
//   5 float). cfg_ready is always high; write only while the stream is idle.
// - An accepted item passes through the three-stage datapath (decode,
//   align/normalize, round/pack) that holds one item per stage. Throughput is
//   one item per cycle while out_tready is held high.
// - Each stage advances when the stage after it is empty or moving, so a
//   stalled receiver backs items up into empty stages first; in_tready drops
//   only when all three stages are full.
// - Synchronous active-low reset empties the pipeline and sets direction 0,
//   format S16.
// ----------------------------------------------------------------------------
module pcm_sample_format_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sample_out
  output logic        out_tlast
);
  import pcmc_pkg::*;

  logic       dir_r;
  logic [2:0] fmt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      fmt_r <= FMT_S16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIRECTION: dir_r <= cfg_data[0];
        CFG_FORMAT:    fmt_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // stage valid bits and backpressure chain
  logic v1_r, v2_r, v3_r;
  logic l1_r, l2_r, l3_r;
  logic rdy1, rdy2, rdy3;
  pipe_en_t en;

  assign rdy3 = !v3_r || out_tready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign en.en1 = rdy1;
  assign en.en2 = rdy2;
  assign en.en3 = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) l1_r <= in_tlast;
    if (rdy2) l2_r <= l1_r;
    if (rdy3) l3_r <= l2_r;
  end

  logic [31:0] i2f_res, f2i_res;

  pcmc_i2f u_i2f (
    .clk      (clk),
    .en       (en),
    .fmt      (fmt_r),
    .sample_i (in_tdata),
    .result_o (i2f_res)
  );

  pcmc_f2i u_f2i (
    .clk      (clk),
    .en       (en),
    .fmt      (fmt_r),
    .sample_i (in_tdata),
    .result_o (f2i_res)
  );

  // the user must keep direction static while items are in flight; the block does not enforce it
  assign out_tvalid = v3_r;
  assign out_tdata  = dir_r ? f2i_res : i2f_res;
  assign out_tlast  = l3_r;

endmodule

@@ rtl/core/pcmc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmc_checker
// Port-level checks for the PCM sample format converter.
// ----------------------------------------------------------------------------
module pcmc_checker (
  input logic clk,
  input logic rst_n,
  input logic cfg_ready,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage empty");

  a_cfg_ready: assert property (@(posedge clk) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind pcm_sample_format_converter pcmc_checker u_pcmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_ready  (cfg_ready),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCM sample format converter.
// Walks every direction/format pair (reserved formats too), sends a short
// directed set of edge samples and then random words, float values and
// rounding ties under varied idle and backpressure patterns. Every output
// item is compared with a bit-exact integer model of the conversion.
// ----------------------------------------------------------------------------
module tb;
  import pcmc_pkg::*;

  // reserved format codes, expected to give zero
  localparam logic [2:0] FMT_RSVD_A = 3'd6;
  localparam logic [2:0] FMT_RSVD_B = 3'd7;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_DIRECTION;
  logic [2:0]  cfg_data = 3'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;   // [31:0] sample_in
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] sample_out
  logic        out_tlast;

  sample_t pending_q[$];
  sample_t converted_q[$];
  logic       cur_dir = 1'b0;
  logic [2:0] cur_fmt = FMT_S16;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  mismatches = 0;
  int  cycles = 0;

  pcm_sample_format_converter dut (.*);

  always #10 clk = ~clk;

  // signed integer times 2^-k, rounded to single precision
  function automatic logic [31:0] int_to_flt(longint v, int k);
    longint mag, rem, half;
    int p, sh;
    logic [31:0] m;
    logic s;
    if (v == 0) return 32'd0;
    s = v < 0;
    mag = s ? -v : v;
    p = 0;
    for (int i = 0; i < 40; i++) if (mag[i]) p = i;
    if (p <= 23) begin
      m = 32'(mag << (23 - p));
    end else begin
      sh = p - 23;
      m = 32'(mag >> sh);
      rem = mag & ((64'sd1 <<< sh) - 1);
      half = 64'sd1 <<< (sh - 1);
      if (rem > half || (rem == half && m[0])) m++;
      if (m == 32'h0100_0000) begin
        m = m >> 1;
        p++;
      end
    end
    return {s, 8'(p - k + 127), m[22:0]};
  endfunction

  // round-half-even of float * 2^s, magnitude saturated at 2^40 (not NaN)
  function automatic longint flt_round(logic [31:0] b, int s);
    longint mag, mant, rem, half;
    int e, sh;
    if (b[30:23] == 8'hFF) begin
      mag = 64'sd1 <<< 40;
    end else begin
      mant = (b[30:23] == 8'd0) ? longint'(b[22:0]) : longint'({1'b1, b[22:0]});
      e = ((b[30:23] == 8'd0) ? -149 : int'(b[30:23]) - 150) + s;
      if (e > 16) mag = 64'sd1 <<< 40;
      else if (e >= 0) mag = mant <<< e;
      else if (-e >= 26) mag = 0;
      else begin
        sh = -e;
        mag = mant >>> sh;
        rem = mant & ((64'sd1 <<< sh) - 1);
        half = 64'sd1 <<< (sh - 1);
        if (rem > half || (rem == half && mag[0])) mag++;
      end
    end
    return b[31] ? -mag : mag;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] convert_sample(logic dir, logic [2:0] fmt,
                                                 logic [31:0] w);
    logic [31:0] b;
    longint r, range;
    int bits, shift;
    logic pos_full, neg_full;
    if (!dir) begin
      case (fmt)
        FMT_U8:   return int_to_flt(longint'(w[7:0]) - 128, 7);
        FMT_S16:  return int_to_flt(longint'($signed(w[15:0])), 15);
        FMT_S24L: return int_to_flt(longint'($signed(w[31:8])), 23);
        FMT_S24R: return int_to_flt(longint'($signed(w)), 23);
        FMT_S32:  return int_to_flt(longint'($signed(w)), 31);
        FMT_FLT:  return w;
        default:  return 32'd0;
      endcase
    end
    // NaN reads as +0.0
    b = (w[30:23] == 8'hFF && w[22:0] != 0) ? 32'd0 : w;
    pos_full = !b[31] && b[30:0] >= FLT_POS_ONE[30:0];
    neg_full = b[31] && b[30:0] >= FLT_POS_ONE[30:0];
    case (fmt)
      FMT_U8: begin
        r = clip(flt_round(b, 7) + 128, 0, 255);
        return {24'd0, r[7:0]};
      end
      FMT_S16: begin
        r = clip(flt_round(b, 15), -32768, 32767);
        return {16'd0, r[15:0]};
      end
      FMT_S24L, FMT_S24R, FMT_S32: begin
        bits = (fmt == FMT_S32) ? 32 : 24;
        shift = (fmt == FMT_S24L) ? 8 : 0;
        range = 64'sd1 <<< (bits - 1);
        if (pos_full) r = range - 128;
        else if (neg_full) r = -range;
        else r = clip(flt_round(b, bits - 1), -range, range - 1);
        return 32'(r <<< shift);
      end
      FMT_FLT: begin
        if (pos_full && b != FLT_POS_ONE) return FLT_POS_ONE;
        if (neg_full && b != FLT_NEG_ONE) return FLT_NEG_ONE;
        return b;
      end
      default: return 32'd0;
    endcase
  endfunction

  // driver: feeds pending items, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        converted_q.push_back('{convert_sample(cur_dir, cur_fmt, in_tdata), in_tlast});
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_t it;
          it = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= it.word;
          in_tlast <= it.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (converted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output item %h last %b", out_tdata, out_tlast);
      end else begin
        sample_t exp_item;
        exp_item = converted_q.pop_front();
        if (exp_item.word !== out_tdata || exp_item.last !== out_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch dir %0d fmt %0d: expected %h/%b got %h/%b",
                     cur_dir, cur_fmt, exp_item.word, exp_item.last,
                     out_tdata, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [2:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DIRECTION) cur_dir = val[0];
    else cur_fmt = val;
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_tvalid || converted_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] special_word(int sel);
    logic [31:0] tbl[22] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h0000_0080, 32'h0000_007F, 32'h0000_8000, 32'h0000_7FFF,
                             FLT_POS_ONE, FLT_NEG_ONE, 32'h7F80_0000, 32'hFF80_0000,
                             32'h7FC0_0000, 32'hFFFF_FFFF, 32'h3F00_0000, 32'h0000_0001,
                             32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h3780_0000, 32'h37C0_0000,
                             32'h3F80_0001, 32'h0080_0000};
    return tbl[sel % 22];
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] m;
    case ($urandom_range(3))
      0: return $urandom;
      1: return special_word($urandom_range(21));
      default: begin
        // float near full scale; low mantissa bits cleared to make ties
        m = $urandom & ~((32'd1 << $urandom_range(22)) - 1);
        case ($urandom_range(9))
          0: return {1'($urandom), 8'd0, m[22:0]};
          1: return {1'($urandom), 8'hFF, m[22:0]};
          default: return {1'($urandom), 8'($urandom_range(95, 130)), m[22:0]};
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [2:0] fmts[8] = '{FMT_U8, FMT_S16, FMT_S24L, FMT_S24R,
                            FMT_S32, FMT_FLT, FMT_RSVD_A, FMT_RSVD_B};
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edges: float to S16
    write_reg(CFG_DIRECTION, 3'd1);
    write_reg(CFG_FORMAT, FMT_S16);
    for (int i = 0; i < 22; i++) pending_q.push_back('{special_word(i), 1'(i & 1)});
    wait_idle();

    phase = 0;
    for (int d = 0; d < 2; d++) begin
      for (int f = 0; f < 8; f++) begin
        // high bits of the direction value are don't-care
        write_reg(CFG_DIRECTION, {2'($urandom), 1'(d)});
        write_reg(CFG_FORMAT, fmts[f]);
        case (phase % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
          default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
        for (int i = 0; i < 120; i++) begin
          pending_q.push_back('{random_word(), 1'($urandom)});
          // sender holds off until the pipeline has emptied
          if (phase == 3 && i == 60) wait_idle();
        end
        wait_idle();
        phase++;
      end
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
